@@ sv/rkl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkl_pkg: shared types and constants
// Op codes, command kinds, register map and the front-to-back command record.
// ----------------------------------------------------------------------------
package rkl_pkg;

    localparam int ADDR_W    = 48;
    localparam int KEY_W     = 8;
    localparam int ID_W      = 16;
    localparam int TID_W     = 8;
    localparam int TIMER_W   = 16;
    localparam int MASK_W    = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [TID_W-1:0]   TID_RESET     = 8'hD0;
    localparam logic [ID_W-1:0]    MAKER_RESET   = 16'h5348;
    localparam logic [ID_W-1:0]    CUSTOMER_RESET = 16'h5843;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd60000;
    localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;

    // input op codes
    localparam logic [1:0] OP_ADV  = 2'd0;
    localparam logic [1:0] OP_PAIR = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAKER    = 2'd0;
    localparam logic [1:0] REG_CUSTOMER = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    typedef enum logic [2:0] {
        CMD_ADV,
        CMD_DROP,
        CMD_PAIR,
        CMD_TICK,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] sender;
        logic [KEY_W-1:0]  key;
        logic [1:0]        channel;
        logic              pair_on;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    maker_id;
        logic [ID_W-1:0]    customer_id;
        logic [TIMER_W-1:0] pair_timeout;
    } cfg_t;

endpackage

@@ sv/rkl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkl_front: request intake and classification
// Filters repeated and foreign advertisements and turns each request into a
// command for the back end.
// ----------------------------------------------------------------------------
module rkl_front #(
    parameter int CHANNELS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rkl_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [15:0]           man_id,
    input  logic [15:0]           usr_id,
    input  logic [7:0]            trans_id,
    input  logic [47:0]           sender,
    input  logic [7:0]            key,
    input  logic [1:0]            channel,
    input  logic                  pair_on,
    output logic                  q_push,
    output rkl_pkg::cmd_t         q_cmd,
    input  logic                  q_full
);
    import rkl_pkg::*;

    logic [TID_W-1:0] last_tid_reg;
    logic [TID_W-1:0] last_tid_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        last_tid_next  = last_tid_reg;
        q_cmd.kind     = CMD_NOP;
        q_cmd.sender   = sender;
        q_cmd.key      = key;
        q_cmd.channel  = channel;
        q_cmd.pair_on  = pair_on;
        case (op)
            OP_ADV:
            begin
                if (trans_id == last_tid_reg)
                begin
                    q_cmd.kind = CMD_DROP;
                end
                else
                begin
                    // id is taken even when the packet turns out foreign
                    if (q_push)
                        last_tid_next = trans_id;
                    if (man_id != cfg.maker_id || usr_id != cfg.customer_id)
                        q_cmd.kind = CMD_DROP;
                    else
                        q_cmd.kind = CMD_ADV;
                end
            end
            OP_PAIR:
            begin
                if ({30'd0, channel} < 32'(CHANNELS))
                    q_cmd.kind = CMD_PAIR;
            end
            OP_TICK: q_cmd.kind = CMD_TICK;
            default: q_cmd.kind = CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_tid_reg <= TID_RESET;
        else
            last_tid_reg <= last_tid_next;
    end

endmodule

@@ sv/rkl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkl_queue: command queue
// Two-entry FIFO that decouples the intake from the execution side.
// ----------------------------------------------------------------------------
module rkl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rkl_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output rkl_pkg::cmd_t pop_cmd,
    output logic          not_empty
);
    import rkl_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ sv/rkl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkl_back: command execution
// Walks the learned pairs of all channels in step, updates pairing state and
// timers, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rkl_back #(
    parameter int CHANNELS = 4,
    parameter int ENTRIES  = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  rkl_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  rkl_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [3:0]    toggle_mask,
    output logic [3:0]    learned_mask,
    output logic [3:0]    pair_end_mask,
    output logic [3:0]    pairing_mask,
    output logic          dropped
);
    import rkl_pkg::*;

    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int EIDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] LAST_E   = CNT_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t              state_reg,  state_next;
    cmd_t                cmd_reg,    cmd_next;
    logic [CNT_W-1:0]    walk_reg,   walk_next;
    logic [CHANNELS-1:0] known_reg,  known_next;
    logic [CHANNELS-1:0] flag_reg,   flag_next;
    logic [TIMER_W-1:0]  timer_reg [CHANNELS];
    logic [TIMER_W-1:0]  timer_next [CHANNELS];
    logic [CNT_W-1:0]    count_reg [CHANNELS];
    logic [CNT_W-1:0]    count_next [CHANNELS];
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          toggle_reg,  toggle_next;
    logic [3:0]          learned_reg, learned_next;
    logic [3:0]          end_reg,     end_next;
    logic [3:0]          pairing_reg, pairing_next;
    logic                dropped_reg, dropped_next;

    // learned pairs, no reset: only entries below the count are ever compared
    logic [ADDR_W-1:0]   addr_store [CHANNELS][ENTRIES];
    logic [KEY_W-1:0]    key_store  [CHANNELS][ENTRIES];
    logic [CHANNELS-1:0] store_wr;

    logic [EIDX_W-1:0]   walk_idx;
    logic [CHANNELS-1:0] toggle_v, learned_v, end_v;

    assign walk_idx      = walk_reg[EIDX_W-1:0];
    assign out_valid     = out_valid_reg;
    assign toggle_mask   = toggle_reg;
    assign learned_mask  = learned_reg;
    assign pair_end_mask = end_reg;
    assign pairing_mask  = pairing_reg;
    assign dropped       = dropped_reg;

    function automatic logic [3:0] low_mask(input logic [CHANNELS-1:0] v);
        logic [CHANNELS+3:0] ext;
        ext = {4'b0000, v};
        return ext[3:0];
    endfunction

    always_comb
    begin
        logic [TIMER_W-1:0] t;
        t              = '0;
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        walk_next      = walk_reg;
        known_next     = known_reg;
        flag_next      = flag_reg;
        timer_next     = timer_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        toggle_next    = toggle_reg;
        learned_next   = learned_reg;
        end_next       = end_reg;
        pairing_next   = pairing_reg;
        dropped_next   = dropped_reg;
        q_pop          = 1'b0;
        store_wr       = '0;
        toggle_v       = '0;
        learned_v      = '0;
        end_v          = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    walk_next  = '0;
                    known_next = '0;
                    state_next = (q_cmd.kind == CMD_ADV) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    if (walk_reg < count_reg[ch] &&
                        addr_store[ch][walk_idx] == cmd_reg.sender &&
                        key_store[ch][walk_idx] == cmd_reg.key)
                        known_next[ch] = 1'b1;
                end
                if (walk_reg == LAST_E)
                    state_next = ST_DONE;
                else
                    walk_next = walk_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    case (cmd_reg.kind)
                        CMD_ADV:
                        begin
                            for (int ch = 0; ch < CHANNELS; ch++)
                            begin
                                if (flag_reg[ch])
                                begin
                                    if (!known_reg[ch])
                                    begin
                                        flag_next[ch]  = 1'b0;
                                        timer_next[ch] = '0;
                                        end_v[ch]      = 1'b1;
                                        if (count_reg[ch] < FULL_CNT)
                                        begin
                                            store_wr[ch]   = 1'b1;
                                            count_next[ch] = count_reg[ch] + 1'b1;
                                            learned_v[ch]  = 1'b1;
                                        end
                                    end
                                end
                                else if (known_reg[ch])
                                begin
                                    toggle_v[ch] = 1'b1;
                                end
                            end
                        end
                        CMD_PAIR:
                        begin
                            for (int ch = 0; ch < CHANNELS; ch++)
                            begin
                                if ({30'd0, cmd_reg.channel} == 32'(ch))
                                begin
                                    flag_next[ch]  = cmd_reg.pair_on;
                                    timer_next[ch] = '0;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            for (int ch = 0; ch < CHANNELS; ch++)
                            begin
                                if (flag_reg[ch])
                                begin
                                    t = (timer_reg[ch] == TIMER_MAX) ? timer_reg[ch]
                                                                     : timer_reg[ch] + 1'b1;
                                    if (t >= cfg.pair_timeout)
                                    begin
                                        flag_next[ch]  = 1'b0;
                                        timer_next[ch] = '0;
                                    end
                                    else
                                    begin
                                        timer_next[ch] = t;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                    out_valid_next = 1'b1;
                    toggle_next    = low_mask(toggle_v);
                    learned_next   = low_mask(learned_v);
                    end_next       = low_mask(end_v);
                    pairing_next   = low_mask(flag_next);
                    dropped_next   = (cmd_reg.kind == CMD_DROP);
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_reg      <= '0;
            known_reg     <= '0;
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                timer_reg[ch] <= '0;
                count_reg[ch] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            known_reg     <= known_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            timer_reg     <= timer_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        toggle_reg  <= toggle_next;
        learned_reg <= learned_next;
        end_reg     <= end_next;
        pairing_reg <= pairing_next;
        dropped_reg <= dropped_next;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (store_wr[ch])
            begin
                addr_store[ch][count_reg[ch][EIDX_W-1:0]] <= cmd_reg.sender;
                key_store[ch][count_reg[ch][EIDX_W-1:0]]  <= cmd_reg.key;
            end
        end
    end

`ifndef SYNTHESIS
    a_learn_implies_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((learned_reg & ~end_reg) == 4'b0000))
        else $error("learned channel without pairing end");

    a_toggle_not_learn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((toggle_reg & (learned_reg | end_reg)) == 4'b0000))
        else $error("channel both toggled and ended pairing");

    a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> ((toggle_reg | learned_reg | end_reg) == 4'b0000))
        else $error("dropped packet changed a channel");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && walk_reg == LAST_E) |=> (state_reg == ST_DONE))
        else $error("entry walk overran");
`endif

endmodule

@@ sv/remote_key_learn_and_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_key_learn_and_match_core: remote button learning receiver
// Learns (sender, key) pairs per channel during a pairing window and reports
// toggles for known pairs; filters repeated and foreign advertisements.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------
//  input     in_valid / in_ready    op man_id usr_id trans_id sender key
//                                   channel pair_on
//  result    out_valid / out_ready  toggle_mask learned_mask pair_end_mask
//                                   pairing_mask dropped
//  config    psel penable pwrite    paddr pwdata prdata (pready tied high)
//
//  Steps: an advertisement passes the back end as pop, a walk over every
//  stored entry slot with all channels compared at once, and finish;
//  other requests go from pop to finish. The entry walk sets the rate.
//  Reset: rst_n clears the entry counts, pairing flags, timers and the last
//  transaction id (to 0xD0); learned pairs are not cleared, no sweep.
//  Stalls: a two-entry queue sits between intake and execution, and the
//  result register lets the next request be popped while a result waits.
//
module remote_key_learn_and_match_core #(
    parameter int CHANNELS = 4,
    parameter int ENTRIES  = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] man_id,
    input  logic [15:0] usr_id,
    input  logic [7:0]  trans_id,
    input  logic [47:0] sender,
    input  logic [7:0]  key,
    input  logic [1:0]  channel,
    input  logic        pair_on,
    // result side
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  toggle_mask,
    output logic [3:0]  learned_mask,
    output logic [3:0]  pair_end_mask,
    output logic [3:0]  pairing_mask,
    output logic        dropped,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rkl_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       cfg_wr;

    logic       q_push;
    cmd_t       q_push_cmd;
    logic       q_full;
    logic       q_pop;
    cmd_t       q_pop_cmd;
    logic       q_not_empty;

    // ------------------------------------------------------------------
    // Register file. Words sit at 4-byte strides; writes past the last
    // register are ignored and read back as zero.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_MAKER:    cfg_next.maker_id     = pwdata[15:0];
                REG_CUSTOMER: cfg_next.customer_id  = pwdata[15:0];
                REG_TIMEOUT:  cfg_next.pair_timeout = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAKER:    prdata = {16'd0, cfg_reg.maker_id};
            REG_CUSTOMER: prdata = {16'd0, cfg_reg.customer_id};
            REG_TIMEOUT:  prdata = {16'd0, cfg_reg.pair_timeout};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.maker_id     <= MAKER_RESET;
            cfg_reg.customer_id  <= CUSTOMER_RESET;
            cfg_reg.pair_timeout <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front: takes requests, marks repeats and foreign ids as drops, queues commands
    // ------------------------------------------------------------------
    rkl_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .man_id   (man_id),
        .usr_id   (usr_id),
        .trans_id (trans_id),
        .sender   (sender),
        .key      (key),
        .channel  (channel),
        .pair_on  (pair_on),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd),
        .q_full   (q_full)
    );

    rkl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_pop_cmd),
        .not_empty (q_not_empty)
    );

    // ------------------------------------------------------------------
    // Back: pair lookup, learning, pairing timers, result register
    // ------------------------------------------------------------------
    rkl_back #(
        .CHANNELS (CHANNELS),
        .ENTRIES  (ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_not_empty),
        .q_cmd         (q_pop_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .toggle_mask   (toggle_mask),
        .learned_mask  (learned_mask),
        .pair_end_mask (pair_end_mask),
        .pairing_mask  (pairing_mask),
        .dropped       (dropped)
    );

endmodule
